FILE: src/gtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtw_pkg
// Shared types and constants of the greedy text line wrapper.
// ----------------------------------------------------------------------------
package gtw_pkg;

   // largest line the stores can hold
   localparam int MAX_LINE_CHARS_DEF = 32;

   // field widths
   localparam int CHAR_W  = 8;
   localparam int NUM_W   = 16;
   localparam int WIDTH_W = 8;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [NUM_W-1:0]   line_num_type;
   typedef logic [WIDTH_W-1:0] width_type;

   // text bytes with a meaning of their own
   localparam char_type CH_CR  = 8'h0D;
   localparam char_type CH_LF  = 8'h0A;
   localparam char_type CH_SP  = 8'h20;
   localparam char_type CH_TAB = 8'h09;

   // line counter limit, also the line number of the error result
   localparam line_num_type LINE_NUM_MAX = 16'hFFFF;

   // line width after reset
   localparam width_type WIDTH_RESET = 8'd1;

   // result queue
   localparam int RSP_FIFO_DEPTH = 2;
   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

   // one result item
   typedef struct packed {
      char_type     char_out;
      logic         char_valid;
      logic         line_end;
      line_num_type line_number;
      logic         done_res;
      logic         overflow_error;
      logic         last_of_run;
   } rsp_item_type;

   // result queue status seen by the sequencer
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             pop;
   } fifo_stat_type;

endpackage

FILE: src/gtw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtw_if
// Valid/ready channels of the wrapper: text bytes in, line characters out.
// ----------------------------------------------------------------------------
interface gtw_req_if;
   import gtw_pkg::*;

   logic     valid;
   logic     ready;
   char_type char_in;
   logic     end_of_text;

   modport source (output valid, char_in, end_of_text, input ready);
   modport sink   (input valid, char_in, end_of_text, output ready);
endinterface

interface gtw_rsp_if;
   import gtw_pkg::*;

   logic         valid;
   logic         ready;
   char_type     char_out;
   logic         char_valid;
   logic         line_end;
   line_num_type line_number;
   logic         done_res;
   logic         overflow_error;
   logic         last_of_run;

   modport source (output valid, char_out, char_valid, line_end, line_number, done_res,
                   overflow_error, last_of_run, input ready);
   modport sink   (input valid, char_out, char_valid, line_end, line_number, done_res,
                   overflow_error, last_of_run, output ready);
endinterface

FILE: src/greedy_text_line_wrapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_text_line_wrapper_top
// Greedy word wrapper over a byte stream, built around a line store and a
// word store.
// ----------------------------------------------------------------------------
// A byte that only extends the current word goes into the word store. A separator
// copies the held word into the line store one character per cycle. Lines
// leave one character per cycle through the store read port and a two-entry
// result queue while the result side takes them. The next byte is taken once
// the previous one has finished; no clearing pass runs after reset.
module greedy_text_line_wrapper_top #(
   parameter int MAX_LINE_CHARS = gtw_pkg::MAX_LINE_CHARS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   gtw_req_if.sink            req_ch,
   gtw_rsp_if.source          rsp_ch,
   input  logic               csr_wr_en,
   input  gtw_pkg::width_type csr_wr_data
);
   import gtw_pkg::*;

   localparam int ADDR_W = (MAX_LINE_CHARS > 1) ? $clog2(MAX_LINE_CHARS) : 1;

   logic              line_we, line_re, word_we, word_re;
   logic [ADDR_W-1:0] line_waddr, line_raddr, word_waddr, word_raddr;
   char_type          line_wdata, line_rdata, word_wdata, word_rdata;
   logic              push;
   rsp_item_type      push_item;
   fifo_stat_type     fifo_stat;

   // sequencer
   gtw_seq #(.MAX_LINE_CHARS(MAX_LINE_CHARS)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fifo_stat   (fifo_stat),
      .push        (push),
      .push_item   (push_item),
      .line_we     (line_we),
      .line_waddr  (line_waddr),
      .line_wdata  (line_wdata),
      .line_re     (line_re),
      .line_raddr  (line_raddr),
      .line_rdata  (line_rdata),
      .word_we     (word_we),
      .word_waddr  (word_waddr),
      .word_wdata  (word_wdata),
      .word_re     (word_re),
      .word_raddr  (word_raddr),
      .word_rdata  (word_rdata)
   );

   // line store
   gtw_ram #(.DEPTH(MAX_LINE_CHARS)) u_line_ram (
      .clock (clock),
      .we    (line_we),
      .waddr (line_waddr),
      .wdata (line_wdata),
      .re    (line_re),
      .raddr (line_raddr),
      .rdata (line_rdata)
   );

   // word store
   gtw_ram #(.DEPTH(MAX_LINE_CHARS)) u_word_ram (
      .clock (clock),
      .we    (word_we),
      .waddr (word_waddr),
      .wdata (word_wdata),
      .re    (word_re),
      .raddr (word_raddr),
      .rdata (word_rdata)
   );

   // result queue
   gtw_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .stat      (fifo_stat),
      .rsp       (rsp_ch)
   );

   // queue never written while full and not draining
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_stat.count != CNT_W'(RSP_FIFO_DEPTH)) || fifo_stat.pop)
      else $error("result queue overrun");

   // line store is never written and read in the same cycle
   a_line_port: assert property (@(posedge clock) disable iff (reset)
      line_we |-> !line_re)
      else $error("line store write and read collide");

   // word store is never written and read in the same cycle
   a_word_port: assert property (@(posedge clock) disable iff (reset)
      word_we |-> !word_re)
      else $error("word store write and read collide");

   // every result flagged as overflow carries the saturated line number
   a_error_number: assert property (@(posedge clock) disable iff (reset)
      (push && push_item.overflow_error) |-> (push_item.line_number == LINE_NUM_MAX))
      else $error("overflow result with wrong line number");

endmodule

FILE: src/gtw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtw_ram
// Character store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gtw_ram #(
   parameter int DEPTH = gtw_pkg::MAX_LINE_CHARS_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               we,
   input  logic [ADDR_W-1:0]  waddr,
   input  gtw_pkg::char_type  wdata,
   input  logic               re,
   input  logic [ADDR_W-1:0]  raddr,
   output gtw_pkg::char_type  rdata
);
   import gtw_pkg::*;

   char_type mem_ff [DEPTH];
   char_type rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/gtw_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtw_rsp_fifo
// Small result queue that decouples the sequencer from the result channel.
// ----------------------------------------------------------------------------
module gtw_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  gtw_pkg::rsp_item_type push_item,
   output gtw_pkg::fifo_stat_type stat,
   gtw_rsp_if.source             rsp
);
   import gtw_pkg::*;

   rsp_item_type     entry_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   rsp_item_type     head;

   assign pop = rsp.ready && (count_ff != '0);

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // head of queue onto the channel
   assign head               = entry_ff[rd_ptr_ff];
   assign rsp.valid          = (count_ff != '0);
   assign rsp.char_out       = head.char_out;
   assign rsp.char_valid     = head.char_valid;
   assign rsp.line_end       = head.line_end;
   assign rsp.line_number    = head.line_number;
   assign rsp.done_res       = head.done_res;
   assign rsp.overflow_error = head.overflow_error;
   assign rsp.last_of_run    = head.last_of_run;

   assign stat.count = count_ff;
   assign stat.pop   = pop;

endmodule

FILE: src/gtw_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtw_seq
// Wrapping sequencer: classifies each byte, moves words into the line store
// and streams lines out of the stores into the result queue.
// ----------------------------------------------------------------------------
module gtw_seq #(
   parameter int MAX_LINE_CHARS = gtw_pkg::MAX_LINE_CHARS_DEF,
   localparam int ADDR_W = (MAX_LINE_CHARS > 1) ? $clog2(MAX_LINE_CHARS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   gtw_req_if.sink                req,
   input  logic                   csr_wr_en,
   input  gtw_pkg::width_type     csr_wr_data,
   input  gtw_pkg::fifo_stat_type fifo_stat,
   output logic                   push,
   output gtw_pkg::rsp_item_type  push_item,
   output logic                   line_we,
   output logic [ADDR_W-1:0]      line_waddr,
   output gtw_pkg::char_type      line_wdata,
   output logic                   line_re,
   output logic [ADDR_W-1:0]      line_raddr,
   input  gtw_pkg::char_type      line_rdata,
   output logic                   word_we,
   output logic [ADDR_W-1:0]      word_waddr,
   output gtw_pkg::char_type      word_wdata,
   output logic                   word_re,
   output logic [ADDR_W-1:0]      word_raddr,
   input  gtw_pkg::char_type      word_rdata
);
   import gtw_pkg::*;

   localparam int LEN_W = $clog2(MAX_LINE_CHARS + 1);
   localparam int SUM_W = LEN_W + 1;
   localparam int CR_W  = CNT_W + 1;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_PLACE    = 8'b0000_0010,
      ST_SPACE    = 8'b0000_0100,
      ST_COPY     = 8'b0000_1000,
      ST_EMIT     = 8'b0001_0000,
      ST_WORD_OUT = 8'b0010_0000,
      ST_CHAR_WR  = 8'b0100_0000,
      ST_REPORT   = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      KIND_CHAR,
      KIND_BLANK,
      KIND_NEWLINE,
      KIND_END
   } kind_type;

   // what to stream and where to go afterwards
   typedef struct packed {
      logic      word;
      logic      last;
      state_type ret;
   } emit_cfg_type;

   // result held in a register until its store read data is back
   typedef struct packed {
      logic         char_valid;
      logic         line_end;
      line_num_type line_number;
      logic         done_res;
      logic         overflow_error;
      logic         last_of_run;
      logic         from_word;
   } tag_type;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   char_type           text_ff, text_in;
   logic [LEN_W-1:0]   line_fill_ff, line_fill_in;
   logic [LEN_W-1:0]   word_fill_ff, word_fill_in;
   line_num_type       counter_ff, counter_in;
   logic               error_ff, error_in;
   width_type          width_ff, width_in;
   emit_cfg_type       em_ff, em_in;
   logic [LEN_W-1:0]   em_idx_ff, em_idx_in;
   logic [LEN_W-1:0]   cp_rd_ff, cp_rd_in;
   logic               cp_pend_ff, cp_pend_in;
   logic [ADDR_W-1:0]  cp_waddr_ff, cp_waddr_in;
   logic               tag_vld_ff, tag_vld_in;
   tag_type            tag_ff, tag_in;

   logic [LEN_W-1:0]   w_eff;
   logic               line_nz;
   logic               word_full;
   logic               place_over;
   logic               char_over;
   logic               credit_ok;
   logic [LEN_W-1:0]   em_len;
   logic               em_end;
   logic               ap_line_nz;
   logic               ap_emit;
   emit_cfg_type       ap_cfg;
   state_type          ap_next;
   logic [LEN_W-1:0]   cp_sum;

   // effective width, clamped to 1..MAX_LINE_CHARS
   always_comb begin
      if (width_ff == '0) begin
         w_eff = LEN_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_LINE_CHARS)) begin
         w_eff = LEN_W'(MAX_LINE_CHARS);
      end else begin
         w_eff = LEN_W'(width_ff);
      end
   end

   // fit checks
   assign line_nz    = (line_fill_ff != '0);
   assign word_full  = (word_fill_ff >= w_eff);
   assign place_over = line_nz &&
      ((SUM_W'(line_fill_ff) + SUM_W'(word_fill_ff) + SUM_W'(1)) > SUM_W'(MAX_LINE_CHARS));
   assign char_over  = line_nz &&
      ((SUM_W'(line_fill_ff) + SUM_W'(word_fill_ff) + SUM_W'(2)) > SUM_W'(w_eff));

   // room in the queue for one more result, counting the one in flight
   assign credit_ok = ((CR_W'(fifo_stat.count) + CR_W'(tag_vld_ff)) - CR_W'(fifo_stat.pop))
                      < CR_W'(RSP_FIFO_DEPTH);

   // current emission length and last-character detect
   assign em_len = em_ff.word ? word_fill_ff : line_fill_ff;
   assign em_end = (em_idx_ff == (em_len - LEN_W'(1)));

   // copy destination address
   assign cp_sum = line_fill_ff + cp_rd_ff;

   // follow-up once a word has been placed
   assign ap_line_nz = (state_ff == ST_COPY) || line_nz;
   always_comb begin
      ap_emit = 1'b0;
      ap_cfg  = '{word: 1'b0, last: 1'b1, ret: ST_IDLE};
      ap_next = ST_IDLE;
      case (kind_ff)
         KIND_NEWLINE: begin
            ap_emit = 1'b1;
         end
         KIND_END: begin
            ap_next = ST_REPORT;
            if (ap_line_nz) begin
               ap_emit = 1'b1;
               ap_cfg  = '{word: 1'b0, last: 1'b0, ret: ST_REPORT};
            end
         end
         default: begin
            ap_next = ST_IDLE;
         end
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);

   // main sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      text_in      = text_ff;
      line_fill_in = line_fill_ff;
      word_fill_in = word_fill_ff;
      counter_in   = counter_ff;
      error_in     = error_ff;
      width_in     = csr_wr_en ? csr_wr_data : width_ff;
      em_in        = em_ff;
      em_idx_in    = em_idx_ff;
      cp_rd_in     = cp_rd_ff;
      cp_pend_in   = 1'b0;
      cp_waddr_in  = cp_waddr_ff;
      tag_vld_in   = 1'b0;
      tag_in       = tag_ff;
      line_we      = 1'b0;
      line_waddr   = '0;
      line_wdata   = '0;
      line_re      = 1'b0;
      line_raddr   = '0;
      word_we      = 1'b0;
      word_waddr   = '0;
      word_wdata   = '0;
      word_re      = 1'b0;
      word_raddr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               text_in = req.char_in;
               if (req.end_of_text) begin
                  kind_in = KIND_END;
               end else if (req.char_in == CH_SP || req.char_in == CH_TAB ||
                            req.char_in == CH_CR) begin
                  kind_in = KIND_BLANK;
               end else if (req.char_in == CH_LF) begin
                  kind_in = KIND_NEWLINE;
               end else begin
                  kind_in = KIND_CHAR;
               end

               if (error_ff) begin
                  // only the end item answers once the count overflowed
                  if (req.end_of_text) begin
                     state_in = ST_REPORT;
                  end
               end else if (req.end_of_text || req.char_in == CH_SP ||
                            req.char_in == CH_TAB || req.char_in == CH_CR ||
                            req.char_in == CH_LF) begin
                  state_in = ST_PLACE;
               end else if (word_full) begin
                  // held word has reached the width: out it goes first
                  em_idx_in = '0;
                  state_in  = ST_EMIT;
                  if (line_nz) begin
                     em_in = '{word: 1'b0, last: 1'b0, ret: ST_WORD_OUT};
                  end else begin
                     em_in = '{word: 1'b1, last: 1'b1, ret: ST_CHAR_WR};
                  end
               end else begin
                  state_in = ST_CHAR_WR;
               end
            end
         end

         ST_WORD_OUT: begin
            em_in     = '{word: 1'b1, last: 1'b1, ret: ST_CHAR_WR};
            em_idx_in = '0;
            state_in  = ST_EMIT;
         end

         ST_CHAR_WR: begin
            // append the byte to the word, early flush when it cannot fit
            word_we      = 1'b1;
            word_waddr   = word_fill_ff[ADDR_W-1:0];
            word_wdata   = text_ff;
            word_fill_in = word_fill_ff + LEN_W'(1);
            if (char_over) begin
               em_in     = '{word: 1'b0, last: 1'b1, ret: ST_IDLE};
               em_idx_in = '0;
               state_in  = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_PLACE: begin
            if (word_fill_ff == '0) begin
               if (ap_emit) begin
                  em_in     = ap_cfg;
                  em_idx_in = '0;
                  state_in  = ST_EMIT;
               end else begin
                  state_in = ap_next;
               end
            end else if (place_over) begin
               em_in     = '{word: 1'b0, last: (kind_ff == KIND_BLANK), ret: ST_SPACE};
               em_idx_in = '0;
               state_in  = ST_EMIT;
            end else begin
               state_in = ST_SPACE;
            end
         end

         ST_SPACE: begin
            if (line_nz) begin
               line_we      = 1'b1;
               line_waddr   = line_fill_ff[ADDR_W-1:0];
               line_wdata   = CH_SP;
               line_fill_in = line_fill_ff + LEN_W'(1);
            end
            cp_rd_in = '0;
            state_in = ST_COPY;
         end

         ST_COPY: begin
            // read word entry, write it to the line in the next cycle
            if (cp_pend_ff) begin
               line_we    = 1'b1;
               line_waddr = cp_waddr_ff;
               line_wdata = word_rdata;
            end
            if (cp_rd_ff != word_fill_ff) begin
               word_re     = 1'b1;
               word_raddr  = cp_rd_ff[ADDR_W-1:0];
               cp_rd_in    = cp_rd_ff + LEN_W'(1);
               cp_pend_in  = 1'b1;
               cp_waddr_in = cp_sum[ADDR_W-1:0];
            end else if (!cp_pend_ff) begin
               line_fill_in = line_fill_ff + word_fill_ff;
               word_fill_in = '0;
               if (ap_emit) begin
                  em_in     = ap_cfg;
                  em_idx_in = '0;
                  state_in  = ST_EMIT;
               end else begin
                  state_in = ap_next;
               end
            end
         end

         ST_EMIT: begin
            if (credit_ok) begin
               tag_vld_in = 1'b1;
               if (counter_ff == LINE_NUM_MAX) begin
                  // count overflow: one error result ends the item
                  tag_in   = '{char_valid: 1'b0, line_end: 1'b0, line_number: LINE_NUM_MAX,
                               done_res: 1'b0, overflow_error: 1'b1, last_of_run: 1'b1,
                               from_word: 1'b0};
                  error_in = 1'b1;
                  state_in = ST_IDLE;
               end else if (em_len == '0) begin
                  // empty line
                  tag_in     = '{char_valid: 1'b0, line_end: 1'b1, line_number: counter_ff,
                                 done_res: 1'b0, overflow_error: 1'b0, last_of_run: em_ff.last,
                                 from_word: 1'b0};
                  counter_in = counter_ff + line_num_type'(1);
                  state_in   = em_ff.ret;
               end else begin
                  if (em_ff.word) begin
                     word_re    = 1'b1;
                     word_raddr = em_idx_ff[ADDR_W-1:0];
                  end else begin
                     line_re    = 1'b1;
                     line_raddr = em_idx_ff[ADDR_W-1:0];
                  end
                  tag_in    = '{char_valid: 1'b1, line_end: em_end, line_number: counter_ff,
                                done_res: 1'b0, overflow_error: 1'b0,
                                last_of_run: em_ff.last && em_end, from_word: em_ff.word};
                  em_idx_in = em_idx_ff + LEN_W'(1);
                  if (em_end) begin
                     counter_in = counter_ff + line_num_type'(1);
                     em_idx_in  = '0;
                     if (em_ff.word) begin
                        word_fill_in = '0;
                     end else begin
                        line_fill_in = '0;
                     end
                     state_in = em_ff.ret;
                  end
               end
            end
         end

         ST_REPORT: begin
            if (credit_ok) begin
               tag_vld_in = 1'b1;
               tag_in     = '{char_valid: 1'b0, line_end: 1'b0,
                              line_number: error_ff ? LINE_NUM_MAX : counter_ff,
                              done_res: 1'b1, overflow_error: error_ff, last_of_run: 1'b1,
                              from_word: 1'b0};
               if (!error_ff) begin
                  line_fill_in = '0;
                  word_fill_in = '0;
                  counter_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         line_fill_ff <= '0;
         word_fill_ff <= '0;
         counter_ff   <= '0;
         error_ff     <= 1'b0;
         width_ff     <= WIDTH_RESET;
         tag_vld_ff   <= 1'b0;
         cp_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_fill_ff <= line_fill_in;
         word_fill_ff <= word_fill_in;
         counter_ff   <= counter_in;
         error_ff     <= error_in;
         width_ff     <= width_in;
         tag_vld_ff   <= tag_vld_in;
         cp_pend_ff   <= cp_pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      text_ff     <= text_in;
      em_ff       <= em_in;
      em_idx_ff   <= em_idx_in;
      cp_rd_ff    <= cp_rd_in;
      cp_waddr_ff <= cp_waddr_in;
      tag_ff      <= tag_in;
   end

   // result assembly once the store data is back
   assign push = tag_vld_ff;
   always_comb begin
      push_item.char_out = '0;
      if (tag_ff.char_valid) begin
         push_item.char_out = tag_ff.from_word ? word_rdata : line_rdata;
      end
      push_item.char_valid     = tag_ff.char_valid;
      push_item.line_end       = tag_ff.line_end;
      push_item.line_number    = tag_ff.line_number;
      push_item.done_res       = tag_ff.done_res;
      push_item.overflow_error = tag_ff.overflow_error;
      push_item.last_of_run    = tag_ff.last_of_run;
   end

endmodule

FILE: tb/greedy_text_line_wrapper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_text_line_wrapper_top_tb
// Drives text bytes through the line wrapper and checks every emitted line
// character against a cycle-free model of the greedy wrapping rules. Covers
// width clamping, separators, chunked long words, width changes on a held
// word, and random text under sender and receiver stalls.
// ----------------------------------------------------------------------------
module greedy_text_line_wrapper_top_tb;
   import gtw_pkg::*;

   localparam int          MAX_RESULTS  = 64;
   localparam int          SETTLE_CYCLES = 100;
   localparam int          HOLD_CYCLES  = 400;
   localparam longint      TIMEOUT_NS   = 2_000_000;

   // expected line characters worked out from the wrapping rules
   class wrap_scoreboard;
      width_type    width_reg;
      char_type     line_buf [MAX_LINE_CHARS_DEF];
      char_type     word_buf [MAX_LINE_CHARS_DEF];
      int unsigned  line_fill;
      int unsigned  word_fill;
      line_num_type line_cnt;
      bit           err_flag;
      rsp_item_type step_out [$];
      rsp_item_type lines_due [$];
      int           fail_count;

      function new();
         width_reg  = WIDTH_RESET;
         line_fill  = 0;
         word_fill  = 0;
         line_cnt   = '0;
         err_flag   = 1'b0;
         fail_count = 0;
      endfunction

      function int unsigned usable_width();
         int unsigned w;
         w = 32'(width_reg);
         if (w == 0) w = 1;
         if (w > MAX_LINE_CHARS_DEF) w = MAX_LINE_CHARS_DEF;
         return w;
      endfunction

      function void add(char_type c, bit cv, bit le, line_num_type n, bit d);
         rsp_item_type r;
         if (step_out.size() >= MAX_RESULTS) return;
         r.char_out       = c;
         r.char_valid     = cv;
         r.line_end       = le;
         r.line_number    = n;
         r.done_res       = d;
         r.overflow_error = err_flag;
         r.last_of_run    = 1'b0;
         step_out.push_back(r);
      endfunction

      // send out the line store or the word store as one line
      function bit put_line(bit from_word);
         int unsigned len;
         len = from_word ? word_fill : line_fill;
         if (line_cnt == LINE_NUM_MAX) begin
            err_flag = 1'b1;
            add(8'h00, 1'b0, 1'b0, LINE_NUM_MAX, 1'b0);
            return 1'b0;
         end
         if (len == 0) begin
            add(8'h00, 1'b0, 1'b1, line_cnt, 1'b0);
         end else begin
            for (int i = 0; i < len; i++)
               add(from_word ? word_buf[i % MAX_LINE_CHARS_DEF]
                             : line_buf[i % MAX_LINE_CHARS_DEF],
                   1'b1, i + 1 == len, line_cnt, 1'b0);
         end
         line_cnt++;
         return 1'b1;
      endfunction

      function bit flush_line();
         bit ok;
         ok = put_line(1'b0);
         line_fill = 0;
         return ok;
      endfunction

      // join the held word to the line, breaking first if it cannot fit
      function bit place_word();
         if (word_fill == 0) return 1'b1;
         if (line_fill > 0 && line_fill + 1 + word_fill > MAX_LINE_CHARS_DEF) begin
            if (!flush_line()) return 1'b0;
         end
         if (line_fill > 0) begin
            line_buf[line_fill % MAX_LINE_CHARS_DEF] = CH_SP;
            line_fill++;
         end
         for (int i = 0; i < word_fill; i++)
            line_buf[(line_fill + i) % MAX_LINE_CHARS_DEF] = word_buf[i % MAX_LINE_CHARS_DEF];
         line_fill += word_fill;
         word_fill = 0;
         return 1'b1;
      endfunction

      // one accepted item: work out the characters it releases
      function void wrap_item(char_type c, logic eot);
         bit          ok;
         int unsigned w;
         step_out.delete();
         ok = 1'b1;
         if (err_flag) begin
            if (eot) add(8'h00, 1'b0, 1'b0, LINE_NUM_MAX, 1'b1);
         end else if (eot) begin
            ok = place_word();
            if (ok && line_fill > 0) ok = flush_line();
            if (ok) begin
               add(8'h00, 1'b0, 1'b0, line_cnt, 1'b1);
               line_fill = 0;
               word_fill = 0;
               line_cnt  = '0;
            end
         end else if (c == CH_SP || c == CH_TAB || c == CH_CR) begin
            ok = place_word();
         end else if (c == CH_LF) begin
            ok = place_word();
            if (ok) ok = flush_line();
         end else begin
            w = usable_width();
            // held word already at full width goes out whole
            if (word_fill >= w) begin
               if (line_fill > 0) ok = flush_line();
               if (ok) ok = put_line(1'b1);
               word_fill = 0;
            end
            if (ok) begin
               word_buf[word_fill % MAX_LINE_CHARS_DEF] = c;
               word_fill++;
               // early break once the word no longer fits after the line
               if (line_fill > 0 && line_fill + 1 + word_fill > w) ok = flush_line();
            end
         end
         if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
         foreach (step_out[i]) lines_due.push_back(step_out[i]);
      endfunction

      function void diff_field(string name, logic [15:0] want_v, logic [15:0] got_v);
         if (got_v !== want_v) begin
            fail_count++;
            $display("%0t mismatch on %s: expected %h actual %h",
                     $time, name, want_v, got_v);
         end
      endfunction

      function void check_line_char(rsp_item_type got);
         rsp_item_type want;
         if (lines_due.size() == 0) begin
            fail_count++;
            $display("%0t unexpected item: expected none actual %h", $time, got);
            return;
         end
         want = lines_due.pop_front();
         diff_field("char_out", 16'(want.char_out), 16'(got.char_out));
         diff_field("char_valid", 16'(want.char_valid), 16'(got.char_valid));
         diff_field("line_end", 16'(want.line_end), 16'(got.line_end));
         diff_field("line_number", want.line_number, got.line_number);
         diff_field("done_res", 16'(want.done_res), 16'(got.done_res));
         diff_field("overflow_error", 16'(want.overflow_error), 16'(got.overflow_error));
         diff_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   width_type   csr_wr_data;
   int unsigned src_idle_pct;
   int unsigned rsp_idle_pct;
   int          hold_requests;

   wrap_scoreboard sb = new();

   gtw_req_if req_if ();
   gtw_rsp_if rsp_if ();

   greedy_text_line_wrapper_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

   // offer one item, with a random gap first, and return at its acceptance
   task automatic send_item(input char_type c, input logic eot);
      if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_if.valid       <= 1'b1;
      req_if.char_in     <= c;
      req_if.end_of_text <= eot;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.wrap_item(c, eot);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_item(char_type'(s[i]), 1'b0);
   endtask

   // stop offering and wait until every expected item is back
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.lines_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input width_type w);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.width_reg = w;
   endtask

   // any byte that extends a word
   function automatic char_type word_byte();
      char_type b;
      do begin
         b = $urandom_range(1) ? char_type'($urandom_range(8'h7A, 8'h61))
                               : char_type'($urandom_range(255));
      end while (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF);
      return b;
   endfunction

   function automatic char_type separator();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 6) return CH_SP;
      if (pick == 6) return CH_TAB;
      if (pick == 7) return CH_CR;
      return CH_LF;
   endfunction

   // mostly words and separators, some stray bytes and end items
   task automatic random_text(input int unsigned n_items);
      int unsigned sent;
      int unsigned wlen;
      int unsigned pick;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_item(char_type'($urandom_range(255)), 1'b0);
            sent++;
         end else if (pick < 12) begin
            send_item(char_type'($urandom_range(255)), 1'b1);
            sent++;
         end else begin
            wlen = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
            repeat (wlen) send_item(word_byte(), 1'b0);
            send_item(separator(), 1'b0);
            sent += wlen + 1;
         end
      end
   endtask

   // result side: check accepted items, stall at random or on request
   initial begin
      int unsigned  hold_left;
      int           holds_seen;
      rsp_item_type got;
      hold_left  = 0;
      holds_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.char_out       = rsp_if.char_out;
            got.char_valid     = rsp_if.char_valid;
            got.line_end       = rsp_if.line_end;
            got.line_number    = rsp_if.line_number;
            got.done_res       = rsp_if.done_res;
            got.overflow_error = rsp_if.overflow_error;
            got.last_of_run    = rsp_if.last_of_run;
            sb.check_line_char(got);
         end
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // stimulus
   initial begin
      width_type width_plan [6];
      width_plan = '{8'd5, 8'd32, 8'd255, 8'd1, 8'd0, 8'd12};
      width_plan[5] = width_type'($urandom_range(31, 2));
      src_idle_pct  = 15;
      rsp_idle_pct  = 80;
      hold_requests = 0;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_if.valid       <= 1'b0;
      req_if.char_in     <= '0;
      req_if.end_of_text <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset width of one: every word goes out a character at a time
      send_string("ab");
      send_item(CH_SP, 1'b0);
      send_item(8'hFF, 1'b1);
      drain();

      // width zero acts as one, extreme byte values
      write_width(8'd0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(CH_LF, 1'b0);
      drain();

      // width above the store size, tab, carriage return and line feed separators, empty line
      write_width(8'd255);
      send_string("hi");
      send_item(CH_TAB, 1'b0);
      send_string("yo");
      send_item(CH_CR, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(CH_LF, 1'b0);
      drain();

      // width lowered under a held word
      write_width(8'd8);
      send_string("abcdefg");
      drain();
      write_width(8'd3);
      send_item(8'h68, 1'b0);
      send_item(CH_LF, 1'b1);
      drain();

      // random text over several widths and stall patterns
      for (int p = 0; p < 6; p++) begin
         src_idle_pct = (p < 2) ? 15 : (p < 4) ? 80 : 0;
         rsp_idle_pct = (p < 2) ? 80 : (p < 4) ? 15 : 0;
         write_width(width_plan[p]);
         if (p == 4) hold_requests++;
         random_text(52);
         drain();
      end

      if (sb.fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
src/gtw_pkg.sv
src/gtw_if.sv
src/gtw_ram.sv
src/gtw_rsp_fifo.sv
src/gtw_seq.sv
src/greedy_text_line_wrapper_top.sv
tb/greedy_text_line_wrapper_top_tb.sv
